// ----- design/byte_ring_queue_with_peek_top_defines.svh -----
// Assertion macros for the port-level checker of the byte ring queue.
`ifndef BYTE_RING_QUEUE_WITH_PEEK_TOP_DEFINES_SVH
`define BYTE_RING_QUEUE_WITH_PEEK_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BRQP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define BRQP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/brqp_pkg.sv -----
// Package with the command, status, state and lane control types of the byte queue.
package brqp_pkg;

    localparam int LANES    = 8;
    localparam int LANE_LW  = 3;
    localparam int FIELD_W  = 10;
    localparam int DATA_W   = 64;

    typedef enum logic [2:0] {
        CMD_ENQUEUE    = 3'd0,
        CMD_DEQUEUE    = 3'd1,
        CMD_PEEK       = 3'd2,
        CMD_NEXT_PEEK  = 3'd3,
        CMD_MOVE_REAR  = 3'd4,
        CMD_MOVE_FRONT = 3'd5,
        CMD_CLEAR      = 3'd6,
        CMD_STATUS     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NO_ROOM = 2'd1,
        STS_NO_DATA = 2'd2,
        STS_BAD_LEN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_lane_ctl;

endpackage

// ----- design/brqp_lane.sv -----
// One byte lane of the banked store: a single-port memory with registered read.
module brqp_lane #(
    parameter int ROWS = 128
) (
    input  logic                    i_clk,
    input  brqp_pkg::t_lane_ctl     i_ctl,
    input  logic [$clog2(ROWS)-1:0] i_row,
    input  logic [7:0]              i_wdata,
    output logic [7:0]              o_rdata
);
    import brqp_pkg::*;

    logic [7:0] r_mem [ROWS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_row] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_row];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/brqp_merge.sv -----
// Merging stage: rotates the eight lane bytes into request order and masks unused bytes.
module brqp_merge (
    input  logic [brqp_pkg::LANES-1:0][7:0]  i_lane_data,
    input  logic [brqp_pkg::LANE_LW-1:0]     i_base_lane,
    input  logic [brqp_pkg::LANE_LW:0]       i_count,
    output logic [brqp_pkg::DATA_W-1:0]      o_bytes
);
    import brqp_pkg::*;

    always_comb begin
        logic [LANE_LW-1:0] lane;
        o_bytes = '0;
        for (int i = 0; i < LANES; i++) begin
            lane = i_base_lane + LANE_LW'(i);
            if ((LANE_LW+1)'(i) < i_count) begin
                o_bytes[8*i +: 8] = i_lane_data[lane];
            end
        end
    end
endmodule

// ----- design/byte_ring_queue_with_peek_top.sv -----
// Top level of the circular byte queue with read, write and peek pointers.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+---------------------------------------------
//  command | i_in_valid  | o_in_ready  | i_command, i_length, i_data_bytes
//  result  | o_out_valid | i_out_ready | o_status, o_count, o_read_bytes, o_*_bytes
//
// After reset the block sweeps the store to zero, one row of eight bytes per cycle;
// no request is taken during that sweep. Good commands that read bytes (dequeue,
// peek, next peek) pass through a merge state: the eight lane memories are read in
// the accept cycle and their registered data merged in the next. All other commands,
// and rejected reads, go straight to the output register. The result sits in an output
// register; a new request is taken only when that register is empty or its result
// leaves in the same cycle, and never during a read's merge cycle.
module byte_ring_queue_with_peek_top #(
    parameter int DEPTH     = 1024,
    parameter int MAX_CHUNK = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_command,
    input  logic [brqp_pkg::FIELD_W-1:0]  i_length,
    input  logic [brqp_pkg::DATA_W-1:0]   i_data_bytes,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [brqp_pkg::FIELD_W-1:0]  o_count,
    output logic [brqp_pkg::DATA_W-1:0]   o_read_bytes,
    output logic [brqp_pkg::FIELD_W-1:0]  o_used_bytes,
    output logic [brqp_pkg::FIELD_W-1:0]  o_free_bytes,
    output logic [brqp_pkg::FIELD_W-1:0]  o_peek_used_bytes
);
    import brqp_pkg::*;

    // Pointer width, row width per lane, and a compare width that covers both
    // the length field and the pointer distances.
    localparam int PW   = $clog2(DEPTH);
    localparam int ROWS = DEPTH / LANES;
    localparam int RW   = $clog2(ROWS);
    localparam int XW   = ((PW > FIELD_W) ? PW : FIELD_W) + 1;

    t_state r_state, n_state;
    logic [PW-1:0] r_rp, r_wp, r_pp, n_rp, n_wp, n_pp;
    logic [RW-1:0] r_clr_row;

    logic                 r_out_valid;
    t_status              r_status, n_status;
    logic [FIELD_W-1:0]   r_count, n_count;
    logic [DATA_W-1:0]    r_read_bytes;
    logic [FIELD_W-1:0]   r_used, r_free, r_pused;
    logic [LANE_LW-1:0]   r_rd_base;
    logic [LANE_LW:0]     r_rd_cnt;

    logic          clearing, accept, is_read, op_ok;
    t_cmd          cmd;
    logic [PW-1:0] used, freeb, pused, used_n, len_p, rd_base, lane_base;
    logic [XW-1:0] len_x;
    logic          too_long;

    logic [LANES-1:0][7:0] lane_rdata;
    logic [DATA_W-1:0]     merged;

    // Output decode of the control state.
    always_comb begin
        clearing   = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: clearing   = 1'b1;
            ST_IDLE:  o_in_ready = !r_out_valid || i_out_ready;
            ST_READ:  o_in_ready = 1'b0;
            default:  o_in_ready = 1'b0;
        endcase
    end

    assign accept  = i_in_valid && o_in_ready;
    assign cmd     = t_cmd'(i_command);
    assign used    = r_wp - r_rp;
    assign freeb   = PW'(DEPTH - 1) - used;
    assign pused   = r_wp - r_pp;
    assign len_x   = XW'(i_length);
    assign len_p   = PW'(i_length);
    assign too_long = i_length > FIELD_W'(MAX_CHUNK);

    // Command decode: status, count and next pointers. Only a good command moves.
    always_comb begin
        n_status = STS_OK;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_pp     = r_pp;
        case (cmd)
            CMD_ENQUEUE: begin
                if (too_long)                   n_status = STS_BAD_LEN;
                else if (len_x > XW'(freeb))    n_status = STS_NO_ROOM;
                else                            n_wp     = r_wp + len_p;
            end
            CMD_DEQUEUE, CMD_PEEK: begin
                if (too_long)                   n_status = STS_BAD_LEN;
                else if (len_x > XW'(used))     n_status = STS_NO_DATA;
                else if (cmd == CMD_DEQUEUE)    n_rp     = r_rp + len_p;
            end
            CMD_NEXT_PEEK: begin
                if (too_long)                   n_status = STS_BAD_LEN;
                else if (len_x > XW'(pused))    n_status = STS_NO_DATA;
                else                            n_pp     = r_pp + len_p;
            end
            CMD_MOVE_REAR: begin
                if (len_x > XW'(freeb))         n_status = STS_NO_ROOM;
                else                            n_wp     = r_wp + len_p;
            end
            CMD_MOVE_FRONT: begin
                if (len_x > XW'(used))          n_status = STS_NO_DATA;
                else                            n_rp     = r_rp + len_p;
            end
            CMD_CLEAR: begin
                n_rp = '0;
                n_wp = '0;
                n_pp = '0;
            end
            default: n_status = STS_OK;
        endcase
    end

    assign op_ok   = (n_status == STS_OK);
    assign is_read = (cmd == CMD_DEQUEUE) || (cmd == CMD_PEEK) || (cmd == CMD_NEXT_PEEK);
    always_comb begin
        n_count = '0;
        if (op_ok && (cmd != CMD_CLEAR) && (cmd != CMD_STATUS)) begin
            n_count = i_length;
        end
    end
    assign used_n  = n_wp - n_rp;
    assign rd_base = (cmd == CMD_NEXT_PEEK) ? r_pp : r_rp;
    assign lane_base = (cmd == CMD_ENQUEUE) ? r_wp : rd_base;

    // Eight byte lanes: byte k of a request lives in lane (base + k) mod 8.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [LANE_LW-1:0] off;
        logic [PW-1:0]      addr;
        t_lane_ctl          ctl;
        logic [RW-1:0]      row;
        logic [7:0]         wdata;

        assign off  = LANE_LW'(l) - lane_base[LANE_LW-1:0];
        assign addr = lane_base + PW'(off);
        assign row  = clearing ? r_clr_row : addr[PW-1:LANE_LW];
        assign ctl.wr_en = clearing || (accept && (cmd == CMD_ENQUEUE) && op_ok
                                        && ({1'b0, off} < i_length[LANE_LW:0]));
        assign ctl.rd_en = accept && is_read;
        assign wdata = clearing ? 8'h00 : i_data_bytes[{off, 3'b000} +: 8];

        brqp_lane #(.ROWS(ROWS)) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_row   (row),
            .i_wdata (wdata),
            .o_rdata (lane_rdata[l])
        );
    end

    brqp_merge u_merge (
        .i_lane_data (lane_rdata),
        .i_base_lane (r_rd_base),
        .i_count     (r_rd_cnt),
        .o_bytes     (merged)
    );

    // Next-state decode.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr_row == {RW{1'b1}}) n_state = ST_IDLE;
            ST_IDLE:  if (accept && is_read && op_ok) n_state = ST_READ;
            ST_READ:  n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_row   <= '0;
            r_rp        <= '0;
            r_wp        <= '0;
            r_pp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            if (accept) begin
                r_rp <= n_rp;
                r_wp <= n_wp;
                r_pp <= n_pp;
                // A good read shows its result only after the merge cycle.
                r_out_valid <= !(is_read && op_ok);
            end else if (r_state == ST_READ) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_count      <= n_count;
            r_read_bytes <= '0;
            r_used       <= FIELD_W'(used_n);
            r_free       <= FIELD_W'(PW'(DEPTH - 1) - used_n);
            r_pused      <= FIELD_W'(n_wp - n_pp);
            r_rd_base    <= rd_base[LANE_LW-1:0];
            r_rd_cnt     <= i_length[LANE_LW:0];
        end else if (r_state == ST_READ) begin
            r_read_bytes <= merged;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_count           = r_count;
    assign o_read_bytes      = r_read_bytes;
    assign o_used_bytes      = r_used;
    assign o_free_bytes      = r_free;
    assign o_peek_used_bytes = r_pused;
endmodule

// ----- design/brqp_checker.sv -----
// Port-level checker of the byte queue, bound to the top level.
`include "byte_ring_queue_with_peek_top_defines.svh"

module brqp_checker #(
    parameter int DEPTH = 1024
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [9:0]  o_count,
    input logic [63:0] o_read_bytes,
    input logic [9:0]  o_used_bytes,
    input logic [9:0]  o_free_bytes
);
    import brqp_pkg::*;

    localparam logic [31:0] DEPTH_M1 = 32'(DEPTH - 1);

    logic [10:0] space_sum;
    logic        space_ok, rejected, reject_clean, out_stall;
    assign space_sum    = {1'b0, o_used_bytes} + {1'b0, o_free_bytes};
    assign space_ok     = (space_sum[9:0] == DEPTH_M1[9:0]);
    assign rejected     = o_out_valid && (o_status != STS_OK);
    assign reject_clean = (o_count == 10'd0) && (o_read_bytes == 64'd0);
    assign out_stall    = o_out_valid && !i_out_ready;

    `BRQP_ASSERT_NOW(a_space_sum, i_clk, i_rst_n, o_out_valid, space_ok)
    `BRQP_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n, rejected, reject_clean)
    `BRQP_ASSERT_NOW(a_read_width, i_clk, i_rst_n, o_out_valid && (o_count > 10'd8), o_read_bytes == 64'd0)
    `BRQP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_read_bytes))
endmodule

bind byte_ring_queue_with_peek_top brqp_checker #(.DEPTH(DEPTH)) u_brqp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_count      (o_count),
    .o_read_bytes (o_read_bytes),
    .o_used_bytes (o_used_bytes),
    .o_free_bytes (o_free_bytes)
);

// ----- tb/tb_queue_checker.sv -----
// Checker that watches both channels of the byte queue, predicts each result and compares.
`timescale 1ns / 1ps
module tb_queue_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_command,
    input  logic [9:0]  i_length,
    input  logic [63:0] i_data_bytes,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [9:0]  i_count,
    input  logic [63:0] i_read_bytes,
    input  logic [9:0]  i_used_bytes,
    input  logic [9:0]  i_free_bytes,
    input  logic [9:0]  i_peek_used_bytes,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);
    import brqp_pkg::*;

    localparam int QDEPTH = 1024;
    localparam int CHUNK  = 8;

    typedef struct packed {
        t_status     status;
        logic [9:0]  count;
        logic [63:0] rd;
        logic [9:0]  used;
        logic [9:0]  free;
        logic [9:0]  pused;
    } t_result;

    logic [7:0] shadow_store [QDEPTH];
    logic [9:0] rd_ptr, wr_ptr, pk_ptr;
    t_result    expected_results [$];

    function automatic logic [63:0] gather_bytes(logic [9:0] at, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) v[8*i +: 8] = shadow_store[10'(at + i)];
        return v;
    endfunction

    // Applies one command to the shadow queue and returns the result it should give.
    function automatic t_result apply_command(t_cmd cmd, logic [9:0] len, logic [63:0] data);
        t_result r;
        int      used, freeb, pused;
        used  = 10'(wr_ptr - rd_ptr);
        freeb = QDEPTH - 1 - used;
        pused = 10'(wr_ptr - pk_ptr);
        r = '0;
        r.status = STS_OK;
        case (cmd)
            CMD_ENQUEUE: begin
                if (len > CHUNK) r.status = STS_BAD_LEN;
                else if (len > freeb) r.status = STS_NO_ROOM;
                else begin
                    for (int i = 0; i < len; i++) shadow_store[10'(wr_ptr + i)] = data[8*i +: 8];
                    wr_ptr  = wr_ptr + len;
                    r.count = len;
                end
            end
            CMD_DEQUEUE, CMD_PEEK: begin
                if (len > CHUNK) r.status = STS_BAD_LEN;
                else if (len > used) r.status = STS_NO_DATA;
                else begin
                    r.rd = gather_bytes(rd_ptr, len);
                    if (cmd == CMD_DEQUEUE) rd_ptr = rd_ptr + len;
                    r.count = len;
                end
            end
            CMD_NEXT_PEEK: begin
                if (len > CHUNK) r.status = STS_BAD_LEN;
                else if (len > pused) r.status = STS_NO_DATA;
                else begin
                    r.rd    = gather_bytes(pk_ptr, len);
                    pk_ptr  = pk_ptr + len;
                    r.count = len;
                end
            end
            CMD_MOVE_REAR: begin
                if (len > freeb) r.status = STS_NO_ROOM;
                else begin
                    wr_ptr  = wr_ptr + len;
                    r.count = len;
                end
            end
            CMD_MOVE_FRONT: begin
                if (len > used) r.status = STS_NO_DATA;
                else begin
                    rd_ptr  = rd_ptr + len;
                    r.count = len;
                end
            end
            CMD_CLEAR: begin
                rd_ptr = '0;
                wr_ptr = '0;
                pk_ptr = '0;
            end
            default: ;
        endcase
        r.used  = 10'(wr_ptr - rd_ptr);
        r.free  = 10'(QDEPTH - 1 - r.used);
        r.pused = 10'(wr_ptr - pk_ptr);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d: %s got %h expected %h", o_checked, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_checked = 0;
        rd_ptr = '0;
        wr_ptr = '0;
        pk_ptr = '0;
        for (int i = 0; i < QDEPTH; i++) shadow_store[i] = '0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("MISMATCH: result with no request outstanding");
                o_errors++;
            end else begin
                e = expected_results.pop_front();
                if (i_status != e.status) report_mismatch("status", i_status, e.status);
                if (i_count != e.count) report_mismatch("count", i_count, e.count);
                if (i_read_bytes != e.rd) report_mismatch("read_bytes", i_read_bytes, e.rd);
                if (i_used_bytes != e.used) report_mismatch("used", i_used_bytes, e.used);
                if (i_free_bytes != e.free) report_mismatch("free", i_free_bytes, e.free);
                if (i_peek_used_bytes != e.pused)
                    report_mismatch("peek_used", i_peek_used_bytes, e.pused);
            end
            o_checked++;
        end
        if (i_rst_n && i_in_valid && i_in_ready)
            expected_results.push_back(apply_command(t_cmd'(i_command), i_length, i_data_bytes));
    end
endmodule

// ----- tb/tb_top.sv -----
// Top of the byte queue testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps
module tb_top;
    import brqp_pkg::*;

    localparam int ITEMS       = 750;
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_command;
    logic [9:0]  i_length;
    logic [63:0] i_data_bytes;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [9:0]  o_count;
    logic [63:0] o_read_bytes;
    logic [9:0]  o_used_bytes;
    logic [9:0]  o_free_bytes;
    logic [9:0]  o_peek_used_bytes;
    int          errors, pending, checked;
    int          cycles;
    // While this is set neither side idles, so back-to-back traffic is exercised.
    logic        no_idle;
    int          requests_sent;

    byte_ring_queue_with_peek_top dut (.*);

    tb_queue_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_command, .i_length,
        .i_data_bytes, .i_out_valid(o_out_valid), .i_out_ready, .i_status(o_status),
        .i_count(o_count), .i_read_bytes(o_read_bytes), .i_used_bytes(o_used_bytes),
        .i_free_bytes(o_free_bytes), .i_peek_used_bytes(o_peek_used_bytes),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The result side stalls about 31 percent of the time, except in the no-idle stretch.
    initial i_out_ready = 1'b0;
    always @(posedge i_clk) i_out_ready <= no_idle || ($urandom_range(99) >= 31);

    // The timeout watchdog: any hang ends the run as a failure.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("** byte_ring_queue_with_peek_top: FAILED **");
            $finish;
        end
    end

    // Presents one request and holds it until the block takes it. A random idle gap
    // may come first; valid only drops when the next request is not sent at once.
    task automatic send_request(t_cmd cmd, int len, logic [63:0] data);
        if (!no_idle) begin
            while ($urandom_range(99) < 31) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_length     <= 10'(len);
        i_data_bytes <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        requests_sent++;
    endtask

    function automatic logic [63:0] random_bytes();
        return {$urandom, $urandom};
    endfunction

    // Random requests, mostly well formed: lengths mostly stay within a chunk, moves take
    // longer ones, and the queue is steered toward a mix of fill levels, with wraps now and then.
    task automatic send_random_request();
        int pick, len;
        t_cmd cmd;
        pick = $urandom_range(99);
        if (pick < 30)      cmd = CMD_ENQUEUE;
        else if (pick < 45) cmd = CMD_DEQUEUE;
        else if (pick < 55) cmd = CMD_PEEK;
        else if (pick < 70) cmd = CMD_NEXT_PEEK;
        else if (pick < 80) cmd = CMD_MOVE_REAR;
        else if (pick < 90) cmd = CMD_MOVE_FRONT;
        else if (pick < 93) cmd = CMD_CLEAR;
        else                cmd = CMD_STATUS;
        if ($urandom_range(19) == 0)
            len = $urandom_range(1023);
        else if (cmd == CMD_MOVE_REAR || cmd == CMD_MOVE_FRONT)
            len = $urandom_range(3) == 0 ? $urandom_range(400) : $urandom_range(16);
        else
            len = $urandom_range(8);
        send_request(cmd, len, random_bytes());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_command     = CMD_STATUS;
        i_length      = '0;
        i_data_bytes  = '0;
        no_idle       = 1'b0;
        requests_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty queue reads, bad lengths, zero lengths and full extremes.
        send_request(CMD_STATUS, 0, '0);
        send_request(CMD_DEQUEUE, 1, '0);
        send_request(CMD_NEXT_PEEK, 1, '0);
        send_request(CMD_MOVE_FRONT, 1, '0);
        send_request(CMD_ENQUEUE, 9, '1);
        send_request(CMD_PEEK, 1023, '0);
        send_request(CMD_ENQUEUE, 0, '1);
        send_request(CMD_ENQUEUE, 8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_ENQUEUE, 8, 64'h0123_4567_89AB_CDEF);
        send_request(CMD_PEEK, 8, '0);
        send_request(CMD_NEXT_PEEK, 5, '0);
        send_request(CMD_DEQUEUE, 8, '0);
        send_request(CMD_NEXT_PEEK, 8, '0);
        // Moving the rear past unwritten bytes exposes zeros from the reset sweep.
        send_request(CMD_MOVE_REAR, 1000, '0);
        send_request(CMD_MOVE_REAR, 100, '0);
        send_request(CMD_MOVE_REAR, 7, '0);
        send_request(CMD_ENQUEUE, 1, '0);
        send_request(CMD_PEEK, 8, '0);
        send_request(CMD_MOVE_FRONT, 1015, '0);
        send_request(CMD_MOVE_FRONT, 1023, '0);
        send_request(CMD_DEQUEUE, 0, '0);
        send_request(CMD_NEXT_PEEK, 3, '0);
        send_request(CMD_CLEAR, 0, '0);
        send_request(CMD_ENQUEUE, 3, 64'hA5A5_A5A5_A5A5_A5A5);
        send_request(CMD_DEQUEUE, 3, '0);

        for (int n = 0; n < ITEMS; n++) begin
            no_idle = (n >= 300 && n < 420);
            send_random_request();
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d requests covering every command, bad lengths, full and empty",
                 requests_sent);
        $display("queue states and pointer wrap; %0d results checked", checked);
        if (errors == 0 && pending == 0) begin
            $display("** byte_ring_queue_with_peek_top: PASSED **");
        end else begin
            $display("** byte_ring_queue_with_peek_top: FAILED **");
        end
        $finish;
    end
endmodule
